// File: hdl/modbus_rtu_request_frame_detector_defines.svh
// Assertion macros for the Modbus RTU request frame detector.
`ifndef MODBUS_RTU_REQUEST_FRAME_DETECTOR_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAME_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MRFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mrfd assertion failed");
// Next-cycle implication, disabled during reset.
`define MRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mrfd assertion failed");
`else
`define MRFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/mrfd_pkg.sv
// Shared types and constants of the Modbus RTU request frame detector.
package mrfd_pkg;

	localparam int WINDOW_DEPTH       = 8;
	localparam int CRC_BYTES          = 6;
	localparam int MAX_READ_REGS_DEF  = 127;

	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [17:0] READ_BYTE_LIMIT = 18'h20000;
	localparam logic [7:0]  STATION_RESET   = 8'd1;

	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT   = 8'd4;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CRC,
		ST_DONE
	} mrfd_state_t;

	// Control of the shared CRC unit.
	typedef struct packed {
		logic init;
		logic en;
	} crc_ctrl_t;

endpackage

// File: hdl/modbus_rtu_request_frame_detector.sv
// Modbus RTU request frame detector: window, sequencer, decode and result register.
// A kept byte moves from IDLE to CRC, where the shared byte-wise CRC unit walks window
// bytes 0..5 one per cycle, then to DONE, which loads the result register once it is
// empty or being drained; a byte dropped while tx_busy is high goes straight to DONE.
// in_ready is high only when idle, so a new byte waits until the last result is loaded.
// Reset (arst_n, asynchronous, active low): window cleared to zero, no pending request,
// station address 1, no result held.
`include "modbus_rtu_request_frame_detector_defines.svh"

module modbus_rtu_request_frame_detector #(
	parameter int MAX_READ_REGISTERS = mrfd_pkg::MAX_READ_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        tx_busy,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_valid,
	output logic        request_cancelled,
	output logic [2:0]  function_code,
	output logic [15:0] first_word,
	output logic [15:0] second_word,
	output logic        read_range_ok,
	output logic [7:0]  reply_byte_count,
	output logic [16:0] start_byte_offset,
	output logic        echo_request
);
	import mrfd_pkg::*;

	localparam logic [15:0] MaxCount = 16'(MAX_READ_REGISTERS);
	localparam logic [2:0]  LastCrcIdx = 3'(CRC_BYTES - 1);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	mrfd_state_t state_q, state_d;
	logic [7:0]  station_q;
	logic [7:0]  window_q [WINDOW_DEPTH];
	logic        pending_q;
	logic        busy_q;       // current byte was dropped
	logic [2:0]  byte_idx_q;   // window byte fed to the CRC unit

	logic        accept;
	logic        load_out;
	crc_ctrl_t   crc_ctrl;
	logic [15:0] crc;

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = tx_busy ? ST_DONE : ST_CRC;
				end
			end
			ST_CRC: begin
				if (byte_idx_q == LastCrcIdx) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		accept        = in_ready && in_valid;
		// Restart the CRC on every kept byte; advance it once per CRC cycle.
		crc_ctrl.init = accept && !tx_busy;
		crc_ctrl.en   = (state_q == ST_CRC);
		// Load the result register once it is empty or being drained.
		load_out      = (state_q == ST_DONE) && (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register; write it only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= STATION_RESET;
		end else if (cfg_wen) begin
			station_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Sliding window: shift in a kept byte at the newest end
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_DEPTH; k++) begin
				window_q[k] <= 8'h00;
			end
		end else if (accept && !tx_busy) begin
			for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
				window_q[k] <= window_q[k + 1];
			end
			window_q[WINDOW_DEPTH - 1] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			byte_idx_q <= '0;
		end else begin
			if (accept) begin
				busy_q     <= tx_busy;
				byte_idx_q <= '0;
			end else if (state_q == ST_CRC) begin
				byte_idx_q <= byte_idx_q + 3'd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared CRC unit, fed window bytes 0..5 in order
	// ------------------------------------------------------------------
	mrfd_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (window_q[byte_idx_q]),
		.crc    (crc)
	);

	// ------------------------------------------------------------------
	// Frame check and decode, evaluated in the DONE state
	// ------------------------------------------------------------------
	logic [7:0]  fc;
	logic        fc_ok;
	logic [15:0] crc_rx;
	logic        frame_ok;
	logic        is_read;
	logic [15:0] w1, w2;
	logic        count_ok;
	logic [17:0] byte_end;
	logic        range_ok;
	logic        cancel;

	always_comb begin
		fc       = window_q[1];
		fc_ok    = (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT) ||
		           (fc == FC_WRITE_SINGLE);
		crc_rx   = {window_q[7], window_q[6]};
		frame_ok = !busy_q && (window_q[0] == station_q) && fc_ok && (crc == crc_rx);
		w1       = {window_q[2], window_q[3]};
		w2       = {window_q[4], window_q[5]};
		is_read  = frame_ok && (fc != FC_WRITE_SINGLE);
		count_ok = (w2 != 16'd0) && (w2 <= MaxCount);
		// A count that passes count_ok is at most 127 by default, so twice it fits in eight bits.
		byte_end = {1'b0, w1, 1'b0} + {10'd0, w2[6:0], 1'b0};
		range_ok = is_read && count_ok && (byte_end <= READ_BYTE_LIMIT);
		cancel   = !busy_q && pending_q;
	end

	// Any kept byte clears the pending flag; a valid frame sets it again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (load_out && !busy_q) begin
			pending_q <= frame_ok;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic        out_valid_q;
	logic        frame_valid_q;
	logic        cancelled_q;
	logic [2:0]  function_code_q;
	logic [15:0] first_word_q;
	logic [15:0] second_word_q;
	logic        read_range_ok_q;
	logic [7:0]  reply_byte_count_q;
	logic [16:0] start_byte_offset_q;
	logic        echo_request_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			frame_valid_q       <= frame_ok;
			cancelled_q         <= cancel;
			function_code_q     <= frame_ok ? fc[2:0] : 3'd0;
			first_word_q        <= frame_ok ? w1 : 16'd0;
			second_word_q       <= frame_ok ? w2 : 16'd0;
			read_range_ok_q     <= range_ok;
			reply_byte_count_q  <= range_ok ? {w2[6:0], 1'b0} : 8'd0;
			start_byte_offset_q <= is_read ? {w1, 1'b0} : 17'd0;
			echo_request_q      <= frame_ok && (fc == FC_WRITE_SINGLE);
		end
	end

	assign out_valid         = out_valid_q;
	assign frame_valid       = frame_valid_q;
	assign request_cancelled = cancelled_q;
	assign function_code     = function_code_q;
	assign first_word        = first_word_q;
	assign second_word       = second_word_q;
	assign read_range_ok     = read_range_ok_q;
	assign reply_byte_count  = reply_byte_count_q;
	assign start_byte_offset = start_byte_offset_q;
	assign echo_request      = echo_request_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A kept byte starts the CRC walk at window byte 0.
	`MRFD_ASSERT_NEXT(a_kept_starts_crc, clk, arst_n, accept && !tx_busy, (state_q == ST_CRC) && (byte_idx_q == 3'd0))
	// A reported valid frame leaves a pending request behind.
	`MRFD_ASSERT_NEXT(a_valid_sets_pending, clk, arst_n, load_out && frame_ok, pending_q && out_valid)
	// A result never both echoes a write and accepts a read.
	`MRFD_ASSERT_IMPLIES(a_echo_read_excl, clk, arst_n, out_valid, !(echo_request && read_range_ok))
	// A dropped byte never reports a frame or a cancellation.
	`MRFD_ASSERT_IMPLIES(a_drop_quiet, clk, arst_n, load_out && busy_q, !frame_ok && !cancel)

endmodule

// File: hdl/mrfd_crc_unit.sv
// Byte-wise Modbus CRC-16 accumulator, one byte per enabled cycle.
module mrfd_crc_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  mrfd_pkg::crc_ctrl_t ctrl,
	input  logic [7:0]         data,
	output logic [15:0]        crc
);
	import mrfd_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// Eight reflected shift steps over one byte.
	always_comb begin
		logic [15:0] acc;
		acc = crc_q ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		crc_next = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.en) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;

endmodule

// File: dv/frame_result_checker.sv
// Watches the detector's channels, predicts each result and compares it on arrival.
`timescale 1ns / 1ps

module frame_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        tx_busy,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        frame_valid,
	input  logic        request_cancelled,
	input  logic [2:0]  function_code,
	input  logic [15:0] first_word,
	input  logic [15:0] second_word,
	input  logic        read_range_ok,
	input  logic [7:0]  reply_byte_count,
	input  logic [16:0] start_byte_offset,
	input  logic        echo_request,
	output int          mismatch_count,
	output int          results_outstanding
);
	import mrfd_pkg::*;

	typedef struct packed {
		logic        frame_valid;
		logic        request_cancelled;
		logic [2:0]  function_code;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic        read_range_ok;
		logic [7:0]  reply_byte_count;
		logic [16:0] start_byte_offset;
		logic        echo_request;
	} frame_result_t;

	logic [7:0]    rx_window [WINDOW_DEPTH];
	logic          request_pending;
	logic [7:0]    station;
	frame_result_t expected_results [$];
	frame_result_t observed;

	assign observed = {frame_valid, request_cancelled, function_code, first_word, second_word,
		read_range_ok, reply_byte_count, start_byte_offset, echo_request};

	// Shift a kept byte into the window and decode the request it may complete.
	function automatic frame_result_t predict_frame_result(input logic [7:0] b, input logic busy);
		frame_result_t r;
		logic [15:0]   crc;
		logic [15:0]   start_reg;
		logic [15:0]   reg_count;
		logic [17:0]   byte_end;
		logic [7:0]    fc;
		int            k;
		int            n;
		r = '0;
		if (busy) begin
			return r;
		end
		for (k = 0; k < WINDOW_DEPTH - 1; k++) begin
			rx_window[k] = rx_window[k + 1];
		end
		rx_window[WINDOW_DEPTH - 1] = b;
		r.request_cancelled = request_pending;
		request_pending = 1'b0;
		crc = CRC_INIT;
		for (k = 0; k < CRC_BYTES; k++) begin
			crc = crc ^ {8'h00, rx_window[k]};
			for (n = 0; n < 8; n++) begin
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
		end
		fc = rx_window[1];
		if (rx_window[0] != station ||
				!(fc == FC_READ_HOLDING || fc == FC_READ_INPUT || fc == FC_WRITE_SINGLE) ||
				crc != {rx_window[7], rx_window[6]}) begin
			return r;
		end
		request_pending = 1'b1;
		start_reg = {rx_window[2], rx_window[3]};
		reg_count = {rx_window[4], rx_window[5]};
		r.frame_valid = 1'b1;
		r.function_code = fc[2:0];
		r.first_word = start_reg;
		r.second_word = reg_count;
		if (fc == FC_WRITE_SINGLE) begin
			r.echo_request = 1'b1;
		end else begin
			r.start_byte_offset = {start_reg, 1'b0};
			byte_end = {1'b0, start_reg, 1'b0} + {1'b0, reg_count, 1'b0};
			if (reg_count >= 1 && reg_count <= MAX_READ_REGS_DEF && byte_end <= READ_BYTE_LIMIT) begin
				r.read_range_ok = 1'b1;
				r.reply_byte_count = {reg_count[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic string describe(input frame_result_t r);
		return $sformatf("valid=%0d cancel=%0d fc=%0d w1=%h w2=%h range_ok=%0d bytes=%0d offset=%h echo=%0d",
			r.frame_valid, r.request_cancelled, r.function_code, r.first_word, r.second_word,
			r.read_range_ok, r.reply_byte_count, r.start_byte_offset, r.echo_request);
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		frame_result_t want;
		int            k;
		if (!arst_n) begin
			for (k = 0; k < WINDOW_DEPTH; k++) begin
				rx_window[k] = '0;
			end
			request_pending = 1'b0;
			station = STATION_RESET;
			expected_results.delete();
			results_outstanding = 0;
			mismatch_count = 0;
		end else begin
			if (cfg_wen) begin
				station = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_frame_result(rx_byte, tx_busy));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: unexpected result: %s", $realtime, describe(observed));
					end
				end else begin
					want = expected_results.pop_front();
					if (observed !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: result mismatch\n  expected %s\n  actual   %s",
								$realtime, describe(want), describe(observed));
						end
					end
				end
			end
			results_outstanding = expected_results.size();
		end
	end

endmodule

// File: dv/testbench.sv
// Stimulus and verdict for the Modbus RTU request frame detector.
`timescale 1ns / 1ps

module testbench;
	import mrfd_pkg::*;

	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_BYTES  = 150;

	typedef logic [7:0][7:0] frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        tx_busy = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        frame_valid;
	logic        request_cancelled;
	logic [2:0]  function_code;
	logic [15:0] first_word;
	logic [15:0] second_word;
	logic        read_range_ok;
	logic [7:0]  reply_byte_count;
	logic [16:0] start_byte_offset;
	logic        echo_request;

	int          mismatch_count;
	int          results_outstanding;
	int          kept_bytes = 0;
	int          stall_left = 0;
	bit          sender_quiet = 1'b0;
	bit          receiver_quiet = 1'b0;
	logic [7:0]  station_now = STATION_RESET;

	always #5 clk = ~clk;

	modbus_rtu_request_frame_detector u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.rx_byte          (rx_byte),
		.tx_busy          (tx_busy),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.frame_valid      (frame_valid),
		.request_cancelled(request_cancelled),
		.function_code    (function_code),
		.first_word       (first_word),
		.second_word      (second_word),
		.read_range_ok    (read_range_ok),
		.reply_byte_count (reply_byte_count),
		.start_byte_offset(start_byte_offset),
		.echo_request     (echo_request)
	);

	frame_result_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wen            (cfg_wen),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.rx_byte            (rx_byte),
		.tx_busy            (tx_busy),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.frame_valid        (frame_valid),
		.request_cancelled  (request_cancelled),
		.function_code      (function_code),
		.first_word         (first_word),
		.second_word        (second_word),
		.read_range_ok      (read_range_ok),
		.reply_byte_count   (reply_byte_count),
		.start_byte_offset  (start_byte_offset),
		.echo_request       (echo_request),
		.mismatch_count     (mismatch_count),
		.results_outstanding(results_outstanding)
	);

	// Result side: after each transfer ready stays low while a random stall count runs down;
	// now and then flip into a quiet stretch where ready never drops.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else if (out_valid && out_ready) begin
			if ($urandom_range(0, 39) == 0) begin
				receiver_quiet = !receiver_quiet;
			end
			stall_left = receiver_quiet ? 0 : $urandom_range(0, 10);
			out_ready <= (stall_left == 0);
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready <= (stall_left == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Modbus CRC-16 over bytes 0..5 of a frame, used to build well-formed requests.
	function automatic logic [15:0] modbus_crc(input frame_t f);
		logic [15:0] acc;
		int          k;
		int          n;
		acc = 16'hFFFF;
		for (k = 0; k < 6; k++) begin
			acc = acc ^ {8'h00, f[k]};
			for (n = 0; n < 8; n++) begin
				acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
			end
		end
		return acc;
	endfunction

	function automatic frame_t make_request(input logic [7:0] addr, input logic [7:0] fc,
			input logic [15:0] w1, input logic [15:0] w2);
		frame_t      f;
		logic [15:0] crc;
		f = '0;
		f[0] = addr;
		f[1] = fc;
		f[2] = w1[15:8];
		f[3] = w1[7:0];
		f[4] = w2[15:8];
		f[5] = w2[7:0];
		crc = modbus_crc(f);
		f[6] = crc[7:0];
		f[7] = crc[15:8];
		return f;
	endfunction

	// Bias start registers toward zero and the top of the map, where the byte range check bites.
	function automatic logic [15:0] pick_start();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFF00 + 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Bias counts toward the edges of 1..127.
	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 6))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'd127;
			3: return 16'd128;
			4: return 16'($urandom_range(1, 127));
			5: return 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [7:0] pick_function();
		case ($urandom_range(0, 2))
			0: return FC_READ_HOLDING;
			1: return FC_READ_INPUT;
			default: return FC_WRITE_SINGLE;
		endcase
	endfunction

	// Offer one byte after a random gap and hold it until the transfer. Valid stays high on
	// return so that a zero-gap follower goes out back to back.
	task automatic send_byte(input logic [7:0] b, input logic busy);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		tx_busy <= busy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (!busy) begin
			kept_bytes++;
		end
	endtask

	// Send the first count bytes of a frame; dropped bytes slip in between now and then
	// and must not disturb the window.
	task automatic send_frame(input frame_t f, input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			send_byte(f[k], 1'b0);
		end
	endtask

	// Stop offering bytes, wait for every expected result, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_station(input logic [7:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		station_now = value;
	endtask

	initial begin
		frame_t      f;
		frame_t      g;
		logic [15:0] crc2;
		logic [7:0]  addr;
		logic [7:0]  fc;
		bit          found;
		int          kind;
		int          n;
		int          phase;
		int          phase_end;

		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset address: a dropped byte, then a read of one register at the very top of
		// the map, which just fits the byte range.
		send_byte(8'hFF, 1'b1);
		send_frame(make_request(STATION_RESET, FC_READ_HOLDING, 16'hFFFF, 16'd1), 8);
		drain();

		// Cancel and new frame on one byte: with address 3, search for nine bytes where both
		// the first eight and the last eight form valid requests.
		write_station(8'd3);
		found = 1'b0;
		for (int t = 0; t < 65536 && !found; t++) begin
			f = make_request(8'd3, FC_READ_HOLDING, {FC_WRITE_SINGLE, 8'h5A}, 16'(t));
			g = f >> 8;
			crc2 = modbus_crc(g);
			found = (crc2[7:0] == f[7]);
		end
		sender_quiet = 1'b1;
		send_frame(f, 8);
		send_byte(crc2[15:8], 1'b0);
		sender_quiet = 1'b0;
		drain();

		// Top address with a single-register write: first word all ones, second word zero.
		write_station(8'hFF);
		send_frame(make_request(8'hFF, FC_WRITE_SINGLE, 16'hFFFF, 16'h0000), 8);
		drain();

		// Random phases, each with its own address: mostly well-formed requests with random
		// content, plus corrupted frames, cut-off frames and noise.
		for (phase = 0; phase < 7; phase++) begin
			drain();
			write_station(phase == 0 ? 8'h00 : phase == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
			phase_end = kept_bytes + PHASE_BYTES;
			while (kept_bytes < phase_end) begin
				sender_quiet = ($urandom_range(0, 5) == 0);
				kind = $urandom_range(0, 19);
				addr = station_now;
				fc = pick_function();
				if (kind == 12 || kind == 13) begin
					addr = station_now ^ 8'($urandom_range(1, 255));
				end
				if (kind == 14) begin
					fc = 8'($urandom_range(0, 255));
				end
				f = make_request(addr, fc, pick_start(), pick_count());
				if (kind == 15) begin
					n = $urandom_range(0, 15);
					f[6 + n / 8][n % 8] = ~f[6 + n / 8][n % 8];
				end
				if (kind <= 15) begin
					send_frame(f, 8);
				end else if (kind == 16) begin
					send_frame(f, $urandom_range(1, 7));
				end else if (kind <= 18) begin
					n = $urandom_range(1, 8);
					repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end else begin
					drain();
				end
			end
		end

		drain();
		if (mismatch_count == 0 && results_outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/mrfd_pkg.sv
hdl/mrfd_crc_unit.sv
hdl/modbus_rtu_request_frame_detector.sv
dv/frame_result_checker.sv
dv/testbench.sv
